[rtl/pidc_pkg.sv]
// Shared types, constants and helpers for the clamped PID controller.
package pidc_pkg;

  // Fraction bits of error, gains, limits and output
  localparam int unsigned FRAC_BITS = 8;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned DIVD_W  = 2 * DATA_W + 1;
  localparam int unsigned MUL_A_W = DATA_W + 1;
  localparam int unsigned MUL_B_W = ACC_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [DATA_W-1:0] LIMIT_LOW_RST  = -16'sd25600;
  localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RST = 16'sd25600;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [PROD_W-1:0]  mul_p_t;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_OUT_LOW    = 3'd3,
    REG_OUT_HIGH   = 3'd4,
    REG_INTEG_LOW  = 3'd5,
    REG_INTEG_HIGH = 3'd6
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_INT_M,
    S_INT_A,
    S_P_M,
    S_P_A,
    S_D_M,
    S_D_A,
    S_I_M,
    S_I_A,
    S_OUT
  } state_e;

  // Divider control and status
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clamp against limit << 16: min with high first, then max with low
  function automatic logic signed [ACC_W+1:0] clamp_integ(
      input logic signed [ACC_W+1:0] v,
      input logic signed [DATA_W-1:0] lo,
      input logic signed [DATA_W-1:0] hi);
    logic signed [ACC_W+1:0] lo_x;
    logic signed [ACC_W+1:0] hi_x;
    logic signed [ACC_W+1:0] r;
    lo_x = {{2{lo[DATA_W-1]}}, lo, {DATA_W{1'b0}}};
    hi_x = {{2{hi[DATA_W-1]}}, hi, {DATA_W{1'b0}}};
    r = v;
    if (r > hi_x) r = hi_x;
    if (r < lo_x) r = lo_x;
    return r;
  endfunction

endpackage

[rtl/pidc_mul.sv]
// Shared signed multiplier used by every product of the controller.
module pidc_mul (
  input  pidc_pkg::mul_a_t a_i,
  input  pidc_pkg::mul_b_t b_i,
  output pidc_pkg::mul_p_t p_o
);
  import pidc_pkg::*;

  // Full-width signed product
  assign p_o = mul_p_t'(a_i) * mul_p_t'(b_i);

endmodule

[rtl/pidc_div.sv]
// Serial restoring divider, one quotient bit per cycle.
module pidc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pidc_pkg::div_ctrl_t            ctrl_i,
  output pidc_pkg::div_stat_t            stat_o,
  output logic [pidc_pkg::DIVD_W-1:0]    quot_o
);
  import pidc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVD_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial  = {rem_q, quo_q[DIVD_W-1]};
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = ctrl_i.dividend;
      dvs_d  = ctrl_i.divisor;
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_d = diff[DATA_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DATA_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

[rtl/pid_controller_clamped_core.sv]
// Top level of the clamped PID controller: sequencer, state and output register.
//
//  channel    direction  payload (low bit up)                 handshake
//  s_axis     in         tdata: err_value, step_time          tvalid/tready
//                        tuser: clear
//  m_axis     out        tdata: drive; tuser: limited         tvalid/tready
//  cfg        in         cfg_idx_i, cfg_data_i                cfg_we_i, no wait
//
// A clear beat goes from acceptance straight to the final state, which loads the
// output register for m_axis. Other beats skip the divider when there is no
// derivative (first step or zero step time); with one, the 33-step serial divider
// runs first. Then come four passes through the shared multiplier, each a multiply
// state and an add state. Reset loads the register defaults and clears the
// controller state at once. The result waits in the output register; a new beat
// is taken meanwhile and holds in the final state until that register is free.
module pid_controller_clamped_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input beats
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [31:0]                        s_axis_tdata_i,  // err_value, step_time
  input  logic [0:0]                         s_axis_tuser_i,  // clear
  // result beats
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [15:0]                        m_axis_tdata_o,  // drive
  output logic [0:0]                         m_axis_tuser_o,  // limited
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pidc_pkg::DATA_W-1:0]        cfg_data_i
);
  import pidc_pkg::*;

  state_e state_q, state_d;

  // Configuration registers
  logic [DATA_W-1:0]        gain_p_q, gain_i_q, gain_d_q;
  logic signed [DATA_W-1:0] out_low_q, out_high_q, integ_low_q, integ_high_q;

  // Controller state
  logic signed [DATA_W-1:0] prev_err_q, prev_err_d;
  logic signed [ACC_W-1:0]  accum_q, accum_d;
  logic                     first_step_q, first_step_d;

  // Per-beat working registers
  logic signed [DATA_W-1:0] e_q, e_d;
  logic [DATA_W-1:0]        dt_q, dt_d;
  logic                     clr_q, clr_d;
  logic                     neg_q, neg_d;
  logic signed [ACC_W-1:0]  deriv_q, deriv_d;
  mul_p_t                   prod_q;
  logic signed [SUM_W-1:0]  sum_q, sum_d;

  // Output register
  logic                     out_valid_q, out_valid_d;
  logic [DATA_W-1:0]        drive_q, drive_d;
  logic                     limited_q, limited_d;

  // Shared units
  mul_a_t    mul_a;
  mul_b_t    mul_b;
  mul_p_t    mul_p;
  div_ctrl_t div_ctrl;
  div_stat_t div_stat;
  logic [DIVD_W-1:0] quot;

  logic                     in_fire, out_fire;
  logic signed [DATA_W-1:0] in_err;
  logic [DATA_W-1:0]        in_dt;
  logic signed [DATA_W:0]   err_diff;
  logic [DATA_W:0]          diff_mag;
  logic signed [ACC_W+1:0]  integ_sum;
  logic signed [ACC_W+1:0]  integ_clamped;
  logic signed [ACC_W+1:0]  recl;
  logic signed [PROD_W-1:0] iterm;
  logic signed [SUM_W-1:0]  shifted;
  logic signed [SUM_W-1:0]  clipped;
  logic signed [SUM_W-1:0]  lo_x, hi_x;
  logic signed [DATA_W-1:0] new_lo, new_hi;

  assign in_err   = s_axis_tdata_i[DATA_W-1:0];
  assign in_dt    = s_axis_tdata_i[2*DATA_W-1:DATA_W];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = out_valid_q && m_axis_tready_i;

  assign s_axis_tready_o = (state_q == S_IDLE) && !div_stat.busy;

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_INT_M: begin
        mul_a = {1'b0, dt_q};
        mul_b = {{(MUL_B_W-DATA_W){e_q[DATA_W-1]}}, e_q};
      end
      S_P_M: begin
        mul_a = {1'b0, gain_p_q};
        mul_b = {{(MUL_B_W-DATA_W){e_q[DATA_W-1]}}, e_q};
      end
      S_D_M: begin
        mul_a = {1'b0, gain_d_q};
        mul_b = {deriv_q[ACC_W-1], deriv_q};
      end
      S_I_M: begin
        mul_a = {1'b0, gain_i_q};
        mul_b = {accum_q[ACC_W-1], accum_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pidc_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  // Derivative numerator as sign and magnitude, scaled by 2^16
  assign err_diff = {in_err[DATA_W-1], in_err} - {prev_err_q[DATA_W-1], prev_err_q};
  assign diff_mag = err_diff[DATA_W] ? (DATA_W+1)'(-err_diff) : err_diff;

  assign div_ctrl.start    = in_fire && !s_axis_tuser_i[0] && !first_step_q && (in_dt != '0);
  assign div_ctrl.dividend = {1'b0, diff_mag[DATA_W-1:0], {DATA_W{1'b0}}};
  assign div_ctrl.divisor  = in_dt;

  pidc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  // Integral update and output shaping
  assign integ_sum     = {{2{accum_q[ACC_W-1]}}, accum_q} + (ACC_W+2)'(prod_q);
  assign integ_clamped = clamp_integ(integ_sum, integ_low_q, integ_high_q);
  assign iterm         = prod_q >>> 16;
  assign shifted       = sum_q >>> FRAC_BITS;
  assign lo_x          = SUM_W'(out_low_q);
  assign hi_x          = SUM_W'(out_high_q);

  always_comb begin
    clipped = shifted;
    if (clipped > hi_x) clipped = hi_x;
    if (clipped < lo_x) clipped = lo_x;
  end

  // Limits as they stand after this cycle's write, for the re-clamp
  always_comb begin
    new_lo = integ_low_q;
    new_hi = integ_high_q;
    if (cfg_we_i && (cfg_idx_i == REG_INTEG_LOW))  new_lo = cfg_data_i;
    if (cfg_we_i && (cfg_idx_i == REG_INTEG_HIGH)) new_hi = cfg_data_i;
    recl = clamp_integ({{2{accum_q[ACC_W-1]}}, accum_q}, new_lo, new_hi);
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    prev_err_d   = prev_err_q;
    accum_d      = accum_q;
    first_step_d = first_step_q;
    e_d          = e_q;
    dt_d         = dt_q;
    clr_d        = clr_q;
    neg_d        = neg_q;
    deriv_d      = deriv_q;
    sum_d        = sum_q;
    drive_d      = drive_q;
    limited_d    = limited_q;
    out_valid_d  = out_valid_q && !out_fire;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          e_d   = in_err;
          dt_d  = in_dt;
          neg_d = err_diff[DATA_W];
          if (s_axis_tuser_i[0]) begin
            clr_d        = 1'b1;
            prev_err_d   = '0;
            accum_d      = '0;
            first_step_d = 1'b1;
            state_d      = S_OUT;
          end else begin
            clr_d        = 1'b0;
            prev_err_d   = in_err;
            first_step_d = 1'b0;
            deriv_d      = '0;
            state_d      = div_ctrl.start ? S_DIV : S_INT_M;
          end
        end
      end
      S_DIV: begin
        // saturate the signed quotient to 32 bits
        if (div_stat.done) begin
          if (!neg_q) begin
            deriv_d = (quot[DIVD_W-1] || quot[ACC_W-1]) ? {1'b0, {(ACC_W-1){1'b1}}}
                                                       : quot[ACC_W-1:0];
          end else begin
            deriv_d = (quot[DIVD_W-1] || quot[ACC_W-1]) ? {1'b1, {(ACC_W-1){1'b0}}}
                                                       : -quot[ACC_W-1:0];
          end
          state_d = S_INT_M;
        end
      end
      S_INT_M: state_d = S_INT_A;
      S_INT_A: begin
        accum_d = integ_clamped[ACC_W-1:0];
        state_d = S_P_M;
      end
      S_P_M: state_d = S_P_A;
      S_P_A: begin
        sum_d   = SUM_W'(prod_q);
        state_d = S_D_M;
      end
      S_D_M: state_d = S_D_A;
      S_D_A: begin
        sum_d   = sum_q + SUM_W'(prod_q);
        state_d = S_I_M;
      end
      S_I_M: state_d = S_I_A;
      S_I_A: begin
        sum_d   = sum_q + SUM_W'(iterm);
        state_d = S_OUT;
      end
      S_OUT: begin
        // load the output register once it is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          if (clr_q) begin
            drive_d   = '0;
            limited_d = 1'b0;
          end else begin
            drive_d   = clipped[DATA_W-1:0];
            limited_d = (clipped != shifted);
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Writing an integral limit re-clamps the stored integral
    if (cfg_we_i && ((cfg_idx_i == REG_INTEG_LOW) || (cfg_idx_i == REG_INTEG_HIGH))) begin
      accum_d = recl[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prev_err_q   <= '0;
      accum_q      <= '0;
      first_step_q <= 1'b1;
      out_valid_q  <= 1'b0;
      clr_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_err_q   <= prev_err_d;
      accum_q      <= accum_d;
      first_step_q <= first_step_d;
      out_valid_q  <= out_valid_d;
      clr_q        <= clr_d;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    e_q       <= e_d;
    dt_q      <= dt_d;
    neg_q     <= neg_d;
    deriv_q   <= deriv_d;
    prod_q    <= mul_p;
    sum_q     <= sum_d;
    drive_q   <= drive_d;
    limited_q <= limited_d;
  end

  // Configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      out_low_q    <= LIMIT_LOW_RST;
      out_high_q   <= LIMIT_HIGH_RST;
      integ_low_q  <= LIMIT_LOW_RST;
      integ_high_q <= LIMIT_HIGH_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_GAIN_P:     gain_p_q     <= cfg_data_i;
        REG_GAIN_I:     gain_i_q     <= cfg_data_i;
        REG_GAIN_D:     gain_d_q     <= cfg_data_i;
        REG_OUT_LOW:    out_low_q    <= cfg_data_i;
        REG_OUT_HIGH:   out_high_q   <= cfg_data_i;
        REG_INTEG_LOW:  integ_low_q  <= cfg_data_i;
        REG_INTEG_HIGH: integ_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = drive_q;
  assign m_axis_tuser_o[0] = limited_q;

  // Checks
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_stat.busy)
    else $error("input ready while divider busy");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser_i[0] && !cfg_we_i) |=>
      ((accum_q == '0) && first_step_q && (prev_err_q == '0)))
    else $error("clear beat did not empty the controller state");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |=> (state_q == S_DIV))
    else $error("divider started without entering the divide state");

endmodule
